// ----- design/lpkt_pkg.sv -----
`timescale 1ns / 1ps
// lpkt_pkg: shared types and codes for the linear probe key table
// request and result payload structs, status and opcode codes, default sizes
// no dependencies

package lpkt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int KEY_BYTES_DEF   = 8;
  localparam int CFG_W           = 7;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 7'd64;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_PRESENT   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic        opcode;
    logic [63:0] key;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] slot_index;
    logic [6:0] comparisons;
  } res_t;

endpackage

// ----- design/linear_probe_key_table.sv -----
`timescale 1ns / 1ps
// linear_probe_key_table: open-addressing key table with linear probing
// hash by byte sum, modulo by a shared compare-subtract unit, one slot read per cycle
// depends on lpkt_pkg
//
// channel   direction  handshake                 payload
// cfg       in         cfg_valid / cfg_ready     cfg_data (table_size)
// req       in         req_valid / req_stall     req (opcode, key)
// res       out        res_valid / res_stall     res (status, slot_index, comparisons)
//
// a request moves from idle through the modulo steps, one per bit of the byte sum, SW being
// the byte sum width (11 for eight key bytes), then probes slots and pushes the result
// the sweep is bounded by the single read port of the key store, one slot per cycle
// an insert of an all-zero key skips hashing and probing
// after reset a clearing pass writes every slot with req_stall high
// a result waits in the output register under res_stall while the next request is taken

module linear_probe_key_table
  import lpkt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_BYTES   = KEY_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             res_valid,
  input  logic             res_stall,
  output res_t             res
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int KW = 8 * KEY_BYTES;
  localparam int SW = $clog2(KEY_BYTES * 255 + 1);
  localparam int MW = $clog2(SW);
  localparam int DW = SW + NW - 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;

  logic [2:0]       state;
  logic [AW-1:0]    clr_addr;
  logic [CFG_W-1:0] table_size;
  logic             op;
  logic [KW-1:0]    key_q;
  logic [NW-1:0]    n_q;
  logic [SW-1:0]    rem;
  logic [DW-1:0]    div;
  logic [MW-1:0]    mstep;
  logic [AW-1:0]    probe_addr;
  logic [NW-1:0]    issued;
  logic [NW-1:0]    visited;
  logic [NW-1:0]    count;
  logic [KW-1:0]    rd_data;
  logic [AW-1:0]    rd_slot;
  logic             rd_vld;
  res_t             res_q;

  logic [KW-1:0]    mem [TABLE_DEPTH];

  logic [NW-1:0]    n_cur;
  logic [SW-1:0]    byte_sum;
  logic             mod_ge;
  logic [SW-1:0]    rem_next;
  logic [NW-1:0]    addr_inc;
  logic [AW-1:0]    next_addr;
  logic             rd_empty;
  logic             rd_hit;
  logic             last;
  logic [NW-1:0]    cnt_inc;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [KW-1:0]    mem_wd;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);

  // slots in use, clamped to 1..TABLE_DEPTH
  always_comb begin
    if (table_size == '0) begin
      n_cur = NW'(1);
    end else if (int'(table_size) > TABLE_DEPTH) begin
      n_cur = NW'(TABLE_DEPTH);
    end else begin
      n_cur = NW'(table_size);
    end
  end

  always_comb begin
    byte_sum = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      byte_sum = byte_sum + SW'(req.key[8*b +: 8]);
    end
  end

  assign mod_ge   = (DW'(rem) >= div);
  assign rem_next = mod_ge ? (rem - SW'(div)) : rem;

  assign addr_inc  = NW'(probe_addr) + NW'(1);
  assign next_addr = (addr_inc == n_q) ? '0 : AW'(addr_inc);

  assign rd_empty = (rd_data == '0);
  assign rd_hit   = (rd_data == key_q);
  assign last     = (visited == NW'(n_q - NW'(1)));
  assign cnt_inc  = count + NW'(!rd_empty);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = rd_slot;
    mem_wd = key_q;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = '0;
    end else if (state == S_PROBE && rd_vld && op == OP_INSERT && rd_empty) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[probe_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      table_size <= TABLE_SIZE_RST;
      res_valid  <= 1'b0;
      rd_vld     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        table_size <= cfg_data;
      end
      if (state == S_PUSH && (!res_valid || !res_stall)) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      rd_vld  <= (state == S_PROBE) && (issued != n_q);
      rd_slot <= probe_addr;

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            op    <= req.opcode;
            key_q <= req.key[KW-1:0];
            n_q   <= n_cur;
            rem   <= byte_sum;
            div   <= {n_cur, {(SW-1){1'b0}}};
            mstep <= MW'(SW - 1);
            res_q.status      <= (req.opcode == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
            res_q.slot_index  <= '0;
            res_q.comparisons <= '0;
            if (req.opcode == OP_INSERT && req.key[KW-1:0] == '0) begin
              state <= S_PUSH;
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          rem   <= rem_next;
          div   <= div >> 1;
          mstep <= mstep - MW'(1);
          if (mstep == '0) begin
            probe_addr <= AW'(rem_next);
            issued     <= '0;
            visited    <= '0;
            count      <= '0;
            state      <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (issued != n_q) begin
            probe_addr <= next_addr;
            issued     <= issued + NW'(1);
          end
          if (rd_vld) begin
            visited <= visited + NW'(1);
            count   <= cnt_inc;
            if (op == OP_INSERT) begin
              if (rd_empty) begin
                res_q.status     <= ST_INSERTED;
                res_q.slot_index <= 6'(rd_slot);
                state            <= S_PUSH;
              end else if (rd_hit) begin
                res_q.status     <= ST_PRESENT;
                res_q.slot_index <= 6'(rd_slot);
                state            <= S_PUSH;
              end else if (last) begin
                state <= S_PUSH;
              end
            end else begin
              if (!rd_empty && rd_hit) begin
                res_q.status      <= ST_FOUND;
                res_q.slot_index  <= 6'(rd_slot);
                res_q.comparisons <= 7'(cnt_inc);
                state             <= S_PUSH;
              end else if (last) begin
                res_q.comparisons <= 7'(cnt_inc);
                state             <= S_PUSH;
              end
            end
          end
        end
        S_PUSH: begin
          if (!res_valid || !res_stall) begin
            res   <= res_q;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_PROBE |-> issued <= n_q)
    else $error("probe issued past slots in use");

  a_home_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PROBE && $past(state) == S_MOD |-> NW'(probe_addr) < n_q)
    else $error("home slot outside table");

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || (state == S_PROBE && op == OP_INSERT)))
    else $error("key store written outside clear or insert");

  a_found_counts: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_FOUND |-> res.comparisons != '0)
    else $error("found with no comparison");

  a_insert_no_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ST_INSERTED || res.status == ST_PRESENT)
      |-> res.comparisons == '0)
    else $error("insert reported comparisons");
`endif

endmodule
